[rtl/gha_pkg.sv]
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and codes for the generational handle allocator: request and
// response beats, action codes, status codes and default sizes.
// ----------------------------------------------------------------------------
package gha_pkg;

   // Default sizes handed to the top level parameters
   localparam int GHA_SLOTS         = 1024;
   localparam int GHA_TYPE_BITS     = 16;
   localparam int GHA_POSITION_BITS = 32;

   // Live counter width and its saturation value
   localparam int           LIVE_W   = 11;
   localparam logic [10:0]  LIVE_MAX = 11'h7FF;

   // Action codes
   localparam logic [2:0] ACT_CREATE       = 3'd0;
   localparam logic [2:0] ACT_DESTROY      = 3'd1;
   localparam logic [2:0] ACT_DESTROY_UNCK = 3'd2;
   localparam logic [2:0] ACT_HAS          = 3'd3;
   localparam logic [2:0] ACT_GET          = 3'd4;
   localparam logic [2:0] ACT_SET          = 3'd5;
   localparam logic [2:0] ACT_GET_UNCK     = 3'd6;
   localparam logic [2:0] ACT_SET_UNCK     = 3'd7;

   // Status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_STALE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] handle_index;
      logic [31:0] handle_generation;
      logic [15:0] record_type;
      logic [31:0] record_position;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [31:0]       out_index;
      logic [31:0]       out_generation;
      logic [15:0]       out_type;
      logic [31:0]       out_position;
      logic [LIVE_W-1:0] live_count;
   } rsp_type;

endpackage

[rtl/generational_handle_allocator_top.sv]
// ----------------------------------------------------------------------------
// generational_handle_allocator_top
// Generational handle table: slot records and generations in synchronous
// memories, with a LIFO free stack of released slots.
// ----------------------------------------------------------------------------
//
//   channel   direction   ports                             beat
//   req       in          req_valid, req_ready, req_data    one action
//   rsp       out         rsp_valid, rsp_ready, rsp_data    one result
//
// A non-create action runs as accept and memory read, then execute and write
// back; a create reads the free stack top on accept and the slot in the pop
// state before execution. The memory read-modify-write of one slot sets this order.
// After reset a clearing pass over every slot sets every record and
// generation to all ones; no beat is accepted during it.
// A full response register stalls execution until rsp_ready; a new request
// is taken while a finished response still waits.
//
module generational_handle_allocator_top
   import gha_pkg::*;
#(
   parameter int SLOTS         = GHA_SLOTS,
   parameter int TYPE_BITS     = GHA_TYPE_BITS,
   parameter int POSITION_BITS = GHA_POSITION_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int REC_W = TYPE_BITS + POSITION_BITS;

   localparam logic [TYPE_BITS-1:0]     TYPE_NONE = {TYPE_BITS{1'b1}};
   localparam logic [POSITION_BITS-1:0] POS_NONE  = {POSITION_BITS{1'b1}};
   localparam logic [CNT_W-1:0]         SLOTS_CNT = CNT_W'(SLOTS);
   localparam logic [IDX_W-1:0]         LAST_IDX  = IDX_W'(SLOTS - 1);

   // State codes
   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_POP   = 2'd2;
   localparam logic [1:0] S_EXEC  = 2'd3;

   // Memories
   logic [REC_W-1:0] rec_mem [SLOTS];
   logic [31:0]      gen_mem [SLOTS];
   logic [IDX_W-1:0] stk_mem [SLOTS];

   // Registers
   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [CNT_W-1:0] depth_ff, depth_in;
   logic [CNT_W-1:0] fresh_ff, fresh_in;
   logic [LIVE_W-1:0] live_ff, live_in;
   req_type          req_ff, req_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic             range_ff, range_in;
   logic             popped_ff, popped_in;
   logic             got_ff, got_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [REC_W-1:0] rec_rd_ff;
   logic [31:0]      gen_rd_ff;
   logic [IDX_W-1:0] stk_rd_ff;

   // Memory port controls
   logic [IDX_W-1:0] rd_addr;
   logic             rd_en;
   logic [IDX_W-1:0] stk_rd_addr;
   logic             rec_we, gen_we, stk_we;
   logic [IDX_W-1:0] wr_addr;
   logic [REC_W-1:0] rec_wd;
   logic [31:0]      gen_wd;

   // Field shaping
   logic [31:0]              type_ext;
   logic [TYPE_BITS-1:0]     new_type;
   logic [POSITION_BITS-1:0] new_pos;
   logic [TYPE_BITS-1:0]     cur_type;
   logic [POSITION_BITS-1:0] cur_pos;
   logic [31:0]              cur_type_ext;
   logic [31:0]              cur_pos_ext;
   logic                     cur_valid;
   logic                     checked;
   logic                     out_free;
   logic                     accept;

   assign type_ext     = 32'(req_ff.record_type);
   assign new_type     = type_ext[TYPE_BITS-1:0];
   assign new_pos      = req_ff.record_position[POSITION_BITS-1:0];
   assign cur_type     = rec_rd_ff[REC_W-1 -: TYPE_BITS];
   assign cur_pos      = rec_rd_ff[POSITION_BITS-1:0];
   assign cur_type_ext = 32'(cur_type);
   assign cur_pos_ext  = 32'(cur_pos);
   assign cur_valid    = (cur_type != TYPE_NONE) && (cur_pos != POS_NONE);
   assign checked      = (req_ff.action == ACT_DESTROY) || (req_ff.action == ACT_HAS) ||
                         (req_ff.action == ACT_GET) || (req_ff.action == ACT_SET);
   assign out_free     = !rsp_valid_ff || rsp_ready;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Stack top address; wraps at an empty stack, where the data goes unused
   assign stk_rd_addr = IDX_W'(depth_ff - CNT_W'(1));

   // Sequencer, execution and write-back
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      depth_in     = depth_ff;
      fresh_in     = fresh_ff;
      live_in      = live_ff;
      req_in       = req_ff;
      slot_in      = slot_ff;
      range_in     = range_ff;
      popped_in    = popped_ff;
      got_in       = got_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_addr      = slot_ff;
      rd_en        = 1'b0;
      rec_we       = 1'b0;
      gen_we       = 1'b0;
      stk_we       = 1'b0;
      wr_addr      = slot_ff;
      rec_wd       = {new_type, new_pos};
      gen_wd       = gen_rd_ff;

      unique case (state_ff)
         S_CLEAR: begin
            // Sweep every slot to the invalid record and all-ones generation
            rec_we  = 1'b1;
            gen_we  = 1'b1;
            wr_addr = clr_ff;
            rec_wd  = {REC_W{1'b1}};
            gen_wd  = 32'hFFFF_FFFF;
            clr_in  = clr_ff + IDX_W'(1);
            if (clr_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               slot_in  = req_data.handle_index[IDX_W-1:0];
               range_in = (req_data.handle_index >= 32'(SLOTS));
               rd_addr  = req_data.handle_index[IDX_W-1:0];
               rd_en    = 1'b1;
               state_in = (req_data.action == ACT_CREATE) ? S_POP : S_EXEC;
            end
         end
         S_POP: begin
            // Pick a freed slot first, else the next fresh one
            popped_in = (depth_ff != '0);
            got_in    = (depth_ff != '0) || (fresh_ff != SLOTS_CNT);
            slot_in   = (depth_ff != '0) ? stk_rd_ff : IDX_W'(fresh_ff);
            rd_addr   = slot_in;
            rd_en     = 1'b1;
            state_in  = S_EXEC;
         end
         S_EXEC: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.status         = ST_OK;
               rsp_in.out_index      = req_ff.handle_index;
               rsp_in.out_generation = 32'd0;
               rsp_in.out_type       = 16'hFFFF;
               rsp_in.out_position   = 32'hFFFF_FFFF;
               state_in              = S_IDLE;
               if (req_ff.action == ACT_CREATE) begin
                  if (got_ff) begin
                     rec_we = 1'b1;
                     gen_we = 1'b1;
                     gen_wd = popped_ff ? gen_rd_ff : 32'd0;
                     if (popped_ff) begin
                        depth_in = depth_ff - CNT_W'(1);
                     end else begin
                        fresh_in = fresh_ff + CNT_W'(1);
                     end
                     if (live_ff != LIVE_MAX) begin
                        live_in = live_ff + LIVE_W'(1);
                     end
                     rsp_in.out_index      = 32'(slot_ff);
                     rsp_in.out_generation = gen_wd;
                  end else begin
                     rsp_in.status    = ST_FULL;
                     rsp_in.out_index = 32'd0;
                  end
               end else if (range_ff) begin
                  rsp_in.status = ST_RANGE;
               end else if (checked &&
                            (req_ff.handle_generation != gen_rd_ff || !cur_valid)) begin
                  rsp_in.status         = ST_STALE;
                  rsp_in.out_generation = gen_rd_ff;
               end else begin
                  rsp_in.out_generation = gen_rd_ff;
                  case (req_ff.action) inside
                     ACT_DESTROY, ACT_DESTROY_UNCK: begin
                        if (depth_ff == SLOTS_CNT) begin
                           rsp_in.status = ST_FULL;
                        end else begin
                           // Push, invalidate and bump the generation
                           stk_we   = 1'b1;
                           rec_we   = 1'b1;
                           gen_we   = 1'b1;
                           rec_wd   = {REC_W{1'b1}};
                           gen_wd   = gen_rd_ff + 32'd1;
                           depth_in = depth_ff + CNT_W'(1);
                           if (live_ff != '0) begin
                              live_in = live_ff - LIVE_W'(1);
                           end
                           rsp_in.out_generation = gen_wd;
                        end
                     end
                     ACT_GET, ACT_GET_UNCK: begin
                        rsp_in.out_type     = cur_type_ext[15:0];
                        rsp_in.out_position = cur_pos_ext;
                     end
                     ACT_SET, ACT_SET_UNCK: begin
                        rec_we = 1'b1;
                     end
                     default: begin
                     end
                  endcase
               end
               rsp_in.live_count = live_in;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         depth_ff     <= '0;
         fresh_ff     <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         depth_ff     <= depth_in;
         fresh_ff     <= fresh_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      slot_ff   <= slot_in;
      range_ff  <= range_in;
      popped_ff <= popped_in;
      got_ff    <= got_in;
      rsp_ff    <= rsp_in;
   end

   // Slot memories: one read port, one write port
   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_mem[wr_addr] <= rec_wd;
      end
      if (gen_we) begin
         gen_mem[wr_addr] <= gen_wd;
      end
      if (rd_en) begin
         rec_rd_ff <= rec_mem[rd_addr];
         gen_rd_ff <= gen_mem[rd_addr];
      end
   end

   // Free stack memory: push at the depth, read the top on accept
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[IDX_W'(depth_ff)] <= slot_ff;
      end
      if (accept) begin
         stk_rd_ff <= stk_mem[stk_rd_addr];
      end
   end

endmodule
